### src/periodic_task_tick_scheduler_assert.svh
// assertion macros for the periodic task tick scheduler checker
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PTTS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptts assertion failed");

// next-cycle implication, disabled in reset
`define PTTS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptts assertion failed");

`endif

### src/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// shared constants, slot entry type and table write type of the scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

   localparam int TASK_SLOTS  = 8;
   localparam int COUNT_WIDTH = 16;

   // field widths of the beats
   localparam int OP_W      = 1;
   localparam int SLOT_W    = 3;
   localparam int MODE_W    = 2;
   localparam int PERIOD_W  = 16;
   localparam int SHOT_W    = 16;
   localparam int MASK_W    = 8;
   localparam int RUN_OUT_W = 16;

   // derived widths
   localparam int SLOT_IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int SLOT_CMP_W = ($clog2(TASK_SLOTS + 1) > SLOT_W) ?
                               $clog2(TASK_SLOTS + 1) : SLOT_W;
   localparam int CMP_W      = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK  = 1'b0;
   localparam logic [OP_W-1:0] OP_SETUP = 1'b1;

   // task modes, code three is stored but acts as disabled
   localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FOREVER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SHOTS   = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]      mode;
      logic                   has_handler;
      logic [PERIOD_W-1:0]    period;
      logic [SHOT_W-1:0]      shots_left;
      logic [COUNT_WIDTH-1:0] run_count;
      logic [COUNT_WIDTH-1:0] tick_count;
   } slot_entry_type;

   typedef struct packed {
      logic                  en;
      logic [SLOT_IDX_W-1:0] addr;
      slot_entry_type        data;
   } tbl_write_type;

endpackage

`default_nettype wire

### src/ptts_if.sv
// ----------------------------------------------------------------------------
// ptts_if
// valid/ready channels carrying request and response beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ptts_req_if import ptts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [SLOT_W-1:0]   slot;
   logic [MODE_W-1:0]   task_mode;
   logic                handler_present;
   logic [PERIOD_W-1:0] period_ticks;
   logic [SHOT_W-1:0]   shot_budget;

   modport source (
      output valid, operation, slot, task_mode, handler_present,
             period_ticks, shot_budget,
      input  ready
   );
   modport sink (
      input  valid, operation, slot, task_mode, handler_present,
             period_ticks, shot_budget,
      output ready
   );
endinterface

interface ptts_rsp_if import ptts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MASK_W-1:0]    fired_mask;
   logic [RUN_OUT_W-1:0] run_count;

   modport source (
      output valid, fired_mask, run_count,
      input  ready
   );
   modport sink (
      input  valid, fired_mask, run_count,
      output ready
   );
endinterface

`default_nettype wire

### src/ptts_slot_table.sv
// ----------------------------------------------------------------------------
// ptts_slot_table
// task slot register file, one write and one read port, cleared by reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptts_slot_table import ptts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tbl_write_type         wr,
   input  wire logic [SLOT_IDX_W-1:0] rd_addr,
   output slot_entry_type             rd_data
);

   slot_entry_type entries_ff [TASK_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '{default: '0};
      end else if (wr.en) begin
         entries_ff[wr.addr] <= wr.data;
      end
   end

   assign rd_data = entries_ff[rd_addr];

endmodule

`default_nettype wire

### src/ptts_tick_unit.sv
// ----------------------------------------------------------------------------
// ptts_tick_unit
// shared per-slot tick update: period compare, shot spend, counter steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptts_tick_unit import ptts_pkg::*; (
   input  wire slot_entry_type cur,
   output slot_entry_type      nxt,
   output logic                fire
);

   logic active;
   logic at_period;
   logic limited;
   logic out_of_shots;

   assign limited      = (cur.mode == MODE_SHOTS);
   assign active       = cur.has_handler && ((cur.mode == MODE_FOREVER) || limited);
   assign at_period    = (CMP_W'(cur.tick_count) == CMP_W'(cur.period));
   assign out_of_shots = limited && (cur.shots_left == '0);

   always_comb begin
      nxt  = cur;
      fire = 1'b0;
      if (active) begin
         if (at_period) begin
            // stalled at period when the shot budget is spent
            if (!out_of_shots) begin
               fire           = 1'b1;
               nxt.tick_count = '0;
               nxt.run_count  = cur.run_count + COUNT_WIDTH'(1);
               if (limited) begin
                  nxt.shots_left = cur.shots_left - SHOT_W'(1);
               end
            end
         end else begin
            nxt.tick_count = cur.tick_count + COUNT_WIDTH'(1);
         end
      end
   end

endmodule

`default_nettype wire

### src/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// task slot table swept one slot per cycle through a shared tick unit
// ----------------------------------------------------------------------------
//
//  channel   | dir | beat contents
//  ----------+-----+--------------------------------------------------------
//  req_chan  | in  | operation, slot, task_mode, handler_present,
//            |     | period_ticks, shot_budget
//  rsp_chan  | out | fired_mask, run_count
//
//  a tick beat is accepted in ST_IDLE, then ST_SWEEP passes each slot in turn
//  through the tick unit and writes it back, then ST_FINISH loads the response
//  register before the next ready
//  a set-up beat: slot written on accept, then response load
//  synchronous reset clears the slot table flops in the reset cycle itself
//  the response register lets a new beat be accepted while the previous
//  response waits; a stalled rsp_chan holds the block in its final cycle
//
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_tick_scheduler import ptts_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   ptts_req_if.sink   req_chan,
   ptts_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // sweep position and per-beat accumulation
   logic [SLOT_IDX_W-1:0] idx_ff,  idx_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [RUN_OUT_W-1:0]  run_ff,  run_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]     rsp_mask_ff,  rsp_mask_in;
   logic [RUN_OUT_W-1:0]  rsp_run_ff,   rsp_run_in;

   tbl_write_type  tbl_wr;
   slot_entry_type tbl_rd;
   slot_entry_type upd;
   slot_entry_type setup_entry;
   logic           upd_fire;
   logic           req_fire;
   logic           req_slot_ok;
   logic           rsp_free;
   logic           sweep_last;
   logic           sweep_hit;

   ptts_slot_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_addr (idx_ff),
      .rd_data (tbl_rd)
   );

   ptts_tick_unit u_tick (
      .cur  (tbl_rd),
      .nxt  (upd),
      .fire (upd_fire)
   );

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   // slot numbers past the table write nothing and read back zero
   assign req_slot_ok      = (SLOT_CMP_W'(req_chan.slot) < SLOT_CMP_W'(TASK_SLOTS));
   assign rsp_free         = !rsp_valid_ff || rsp_chan.ready;
   assign sweep_last       = (idx_ff == SLOT_IDX_W'(TASK_SLOTS - 1));
   assign sweep_hit        = (SLOT_CMP_W'(idx_ff) == SLOT_CMP_W'(slot_ff));

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.fired_mask = rsp_mask_ff;
   assign rsp_chan.run_count  = rsp_run_ff;

   // set-up clears the tick and run counters
   always_comb begin
      setup_entry.mode        = req_chan.task_mode;
      setup_entry.has_handler = req_chan.handler_present;
      setup_entry.period      = req_chan.period_ticks;
      setup_entry.shots_left  = req_chan.shot_budget;
      setup_entry.run_count   = '0;
      setup_entry.tick_count  = '0;
   end

   // table write: set-up on accept, else write-back during the sweep
   always_comb begin
      tbl_wr.en   = 1'b0;
      tbl_wr.addr = idx_ff;
      tbl_wr.data = upd;
      if (state_ff == ST_SWEEP) begin
         tbl_wr.en = 1'b1;
      end else if (req_fire && (req_chan.operation == OP_SETUP) && req_slot_ok) begin
         tbl_wr.en   = 1'b1;
         tbl_wr.addr = SLOT_IDX_W'(req_chan.slot);
         tbl_wr.data = setup_entry;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      mask_in      = mask_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_run_in   = rsp_run_ff;

      // downstream takes the waiting beat
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               slot_in = req_chan.slot;
               idx_in  = '0;
               mask_in = '0;
               run_in  = '0;
               if (req_chan.operation == OP_SETUP) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            // slots past the mask width still run but do not show
            if (upd_fire) begin
               mask_in = mask_ff | (MASK_W'(1) << idx_ff);
            end
            if (sweep_hit) begin
               run_in = RUN_OUT_W'(upd.run_count);
            end
            idx_in = idx_ff + SLOT_IDX_W'(1);
            if (sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_ff;
               rsp_run_in   = run_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      mask_ff     <= mask_in;
      run_ff      <= run_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_run_ff  <= rsp_run_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### src/ptts_checker.sv
// ----------------------------------------------------------------------------
// ptts_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_task_tick_scheduler_assert.svh"

module ptts_checker import ptts_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [MASK_W-1:0]    fired_mask,
   input wire logic [RUN_OUT_W-1:0] run_count
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pending_ff, pending_in;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // beats accepted and not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // one beat in work at a time
   `PTTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_beat, !req_ready)

   // a stalled response holds its beat
   `PTTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(fired_mask) && $stable(run_count))

   // no response without an accepted request behind it
   `PTTS_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_valid, pending_ff != 2'd0)

   // no slot outside the table ever fires
   `PTTS_ASSERT_NOW(a_mask_in_table, clock, reset, rsp_valid,
      (fired_mask >> TASK_SLOTS) == '0)

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .fired_mask (rsp_chan.fired_mask),
   .run_count  (rsp_chan.run_count)
);

`default_nettype wire
